FILE: design/md4_pkg.sv
package md4_pkg;

	// one input item: optional message byte plus end flag
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_item_t;

	// one digest word as it leaves the block
	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_number;
		logic        last_word;
	} out_item_t;

	localparam logic [31:0] K2 = 32'h5A827999;
	localparam logic [31:0] K3 = 32'h6ED9EBA1;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [7:0]  PAD_MARK = 8'h80;

	localparam int BLK_WORDS = 16;
	localparam int STEPS     = 48;
	localparam int LEN_POS   = 56;

	// write commands from the front into the block buffer
	typedef struct packed {
		logic        byte_we;
		logic        pad_we;
		logic        pad_mark;
		logic        len_we;
		logic [5:0]  pos;
		logic [7:0]  data;
		logic [63:0] len;
		logic        commit;
		logic        commit_final;
	} blk_wr_t;

	// block buffer status seen by front and back
	typedef struct packed {
		logic wr_free;
		logic head_valid;
		logic head_final;
	} blk_stat_t;

	// message word used by a compression step
	function automatic logic [3:0] msg_index(input logic [5:0] step);
		logic [3:0] j;
		j = step[3:0];
		case (step[5:4])
			2'd0: msg_index = j;
			2'd1: msg_index = {j[1:0], j[3:2]};
			2'd2: msg_index = {j[0], j[1], j[2], j[3]};
			default: msg_index = j;
		endcase
	endfunction

	// rotate amount of a compression step
	function automatic logic [4:0] shift_amt(input logic [5:0] step);
		case (step[5:4])
			2'd0: begin
				case (step[1:0])
					2'd0: shift_amt = 5'd3;
					2'd1: shift_amt = 5'd7;
					2'd2: shift_amt = 5'd11;
					default: shift_amt = 5'd19;
				endcase
			end
			2'd1: begin
				case (step[1:0])
					2'd0: shift_amt = 5'd3;
					2'd1: shift_amt = 5'd5;
					2'd2: shift_amt = 5'd9;
					default: shift_amt = 5'd13;
				endcase
			end
			default: begin
				case (step[1:0])
					2'd0: shift_amt = 5'd3;
					2'd1: shift_amt = 5'd9;
					2'd2: shift_amt = 5'd11;
					default: shift_amt = 5'd15;
				endcase
			end
		endcase
	endfunction

	// round function with the round constant folded in
	function automatic logic [31:0] round_f(input logic [1:0] rnd, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		case (rnd)
			2'd0: round_f = d ^ (b & (c ^ d));
			2'd1: round_f = ((b & (c | d)) | (c & d)) + K2;
			default: round_f = (b ^ c ^ d) + K3;
		endcase
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] t;
		t = {v, v} << s;
		return t[63:32];
	endfunction

endpackage

FILE: design/md4_hash_engine.sv
// MD4 digest engine: takes one item per cycle (an optional message byte and an end
// flag) and, for each finished message, returns four little-endian 32-bit digest
// words in order, word 3 flagged as last, then starts afresh on the next message.
// Bytes are packed into a two-entry 64-byte block buffer; the compression unit
// works each block through a start state, 48 steps and a chaining add, so a
// stream keeps one byte per cycle while the other block entry fills. Ending a
// message takes one or two padding states (pad, then length), then one or two
// compressions (two when fewer than 8 bytes are left after the 0x80 marker),
// then queues the four digest words; input stalls (full) while padding
// or while both block entries wait on the compression unit.
module md4_hash_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  md4_pkg::in_item_t   item,
	output logic                empty,
	input  logic                pop,
	output md4_pkg::out_item_t  result
);

	md4_pkg::blk_wr_t   wr;
	md4_pkg::blk_stat_t stat;
	logic               blk_pop;
	logic [3:0]         rd_idx;
	logic [31:0]        rd_word;

	md4_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.stat   (stat),
		.wr     (wr)
	);

	md4_blkq u_blkq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.pop     (blk_pop),
		.rd_idx  (rd_idx),
		.stat    (stat),
		.rd_word (rd_word)
	);

	md4_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.stat    (stat),
		.blk_pop (blk_pop),
		.rd_idx  (rd_idx),
		.rd_word (rd_word),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

FILE: design/md4_blkq.sv
module md4_blkq (
	input  logic              clk,
	input  logic              arst_n,
	input  md4_pkg::blk_wr_t  wr,
	input  logic              pop,
	input  logic [3:0]        rd_idx,
	output md4_pkg::blk_stat_t stat,
	output logic [31:0]       rd_word
);

	logic [31:0] blk_q [2][md4_pkg::BLK_WORDS];
	logic [1:0]  occ_q;
	logic [1:0]  fin_q;
	logic        wr_ptr_q;
	logic        rd_ptr_q;

	// byte lanes, padding and length land in the entry being filled
	always_ff @(posedge clk) begin
		for (int w = 0; w < md4_pkg::BLK_WORDS; w++) begin
			for (int l = 0; l < 4; l++) begin
				if (wr.byte_we && 6'(4 * w + l) == wr.pos)
					blk_q[wr_ptr_q][w][8*l +: 8] <= wr.data;
				if (wr.pad_we) begin
					if (6'(4 * w + l) == wr.pos)
						blk_q[wr_ptr_q][w][8*l +: 8] <= wr.pad_mark ? md4_pkg::PAD_MARK : 8'h00;
					else if (6'(4 * w + l) > wr.pos)
						blk_q[wr_ptr_q][w][8*l +: 8] <= 8'h00;
				end
			end
		end
		if (wr.len_we) begin
			blk_q[wr_ptr_q][md4_pkg::BLK_WORDS-2] <= wr.len[31:0];
			blk_q[wr_ptr_q][md4_pkg::BLK_WORDS-1] <= wr.len[63:32];
		end
	end

	// occupancy and pointers of the two block entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			fin_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (wr.commit) begin
				occ_q[wr_ptr_q] <= 1'b1;
				fin_q[wr_ptr_q] <= wr.commit_final;
				wr_ptr_q        <= ~wr_ptr_q;
			end
			if (pop) begin
				occ_q[rd_ptr_q] <= 1'b0;
				rd_ptr_q        <= ~rd_ptr_q;
			end
		end
	end

	assign stat.wr_free    = ~occ_q[wr_ptr_q];
	assign stat.head_valid = occ_q[rd_ptr_q];
	assign stat.head_final = fin_q[rd_ptr_q];
	assign rd_word         = blk_q[rd_ptr_q][rd_idx];

endmodule

FILE: design/md4_front.sv
module md4_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  md4_pkg::in_item_t   item,
	input  md4_pkg::blk_stat_t  stat,
	output md4_pkg::blk_wr_t    wr
);

	typedef enum logic [2:0] {
		FS_IDLE = 3'b001,
		FS_PAD  = 3'b010,
		FS_LEN  = 3'b100
	} front_state_t;

	front_state_t state_q;
	logic [63:0]  count_q;
	logic [5:0]   pos;
	logic         accept;
	logic         len_fits;

	assign pos      = count_q[8:3];
	assign full     = (state_q != FS_IDLE) || !stat.wr_free;
	assign accept   = push && !full;
	assign len_fits = pos < 6'(md4_pkg::LEN_POS);

	// buffer write commands
	always_comb begin
		wr      = '0;
		wr.pos  = pos;
		wr.data = item.data_byte;
		wr.len  = count_q;
		case (state_q)
			FS_IDLE: begin
				if (accept && item.byte_valid) begin
					wr.byte_we = 1'b1;
					wr.commit  = (pos == 6'h3F);
				end
			end
			FS_PAD: begin
				if (stat.wr_free) begin
					wr.pad_we       = 1'b1;
					wr.pad_mark     = 1'b1;
					wr.len_we       = len_fits;
					wr.commit       = 1'b1;
					wr.commit_final = len_fits;
				end
			end
			FS_LEN: begin
				if (stat.wr_free) begin
					wr.pos          = '0;
					wr.pad_we       = 1'b1;
					wr.len_we       = 1'b1;
					wr.commit       = 1'b1;
					wr.commit_final = 1'b1;
				end
			end
			default: wr = '0;
		endcase
	end

	// message bit count and padding sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				FS_IDLE: begin
					if (accept) begin
						if (item.byte_valid)
							count_q <= count_q + 64'd8;
						if (item.end_of_message)
							state_q <= FS_PAD;
					end
				end
				FS_PAD: begin
					if (stat.wr_free) begin
						if (len_fits) begin
							count_q <= '0;
							state_q <= FS_IDLE;
						end else begin
							state_q <= FS_LEN;
						end
					end
				end
				FS_LEN: begin
					if (stat.wr_free) begin
						count_q <= '0;
						state_q <= FS_IDLE;
					end
				end
				default: state_q <= FS_IDLE;
			endcase
		end
	end

endmodule

FILE: design/md4_core.sv
module md4_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  md4_pkg::blk_stat_t   stat,
	output logic                 blk_pop,
	output logic [3:0]           rd_idx,
	input  logic [31:0]          rd_word,
	output logic                 empty,
	input  logic                 pop,
	output md4_pkg::out_item_t   result
);

	typedef enum logic [3:0] {
		CS_IDLE = 4'b0001,
		CS_RUN  = 4'b0010,
		CS_ADD  = 4'b0100,
		CS_EMIT = 4'b1000
	} core_state_t;

	core_state_t         state_q;
	logic [31:0]         chain_q [4];
	logic [31:0]         a_q, b_q, c_q, d_q;
	logic [5:0]          step_q;
	logic                fin_q;
	logic [1:0]          emit_n_q;
	md4_pkg::out_item_t  ofifo_q [4];
	logic [1:0]          owr_q, ord_q;
	logic [2:0]          ocnt_q;
	logic [31:0]         new_a;
	logic                last_step;
	logic                opush;
	logic                opop;

	// one compression step per cycle
	assign rd_idx    = md4_pkg::msg_index(step_q);
	assign new_a     = md4_pkg::rotl32(a_q + md4_pkg::round_f(step_q[5:4], b_q, c_q, d_q)
		+ rd_word, md4_pkg::shift_amt(step_q));
	assign last_step = (step_q == 6'(md4_pkg::STEPS - 1));
	assign blk_pop   = (state_q == CS_RUN) && last_step;

	assign opush  = (state_q == CS_EMIT) && (ocnt_q != 3'd4);
	assign opop   = pop && !empty;
	assign empty  = (ocnt_q == 3'd0);
	assign result = ofifo_q[ord_q];

	// working registers: roles rotate a, d, c, b every step
	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == CS_RUN) begin
			a_q <= d_q;
			b_q <= new_a;
			c_q <= b_q;
			d_q <= c_q;
		end
		if (opush) begin
			ofifo_q[owr_q].digest_word <= chain_q[emit_n_q];
			ofifo_q[owr_q].word_number <= emit_n_q;
			ofifo_q[owr_q].last_word   <= (emit_n_q == 2'd3);
		end
	end

	// block sequencing, chaining words and digest output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CS_IDLE;
			chain_q[0] <= md4_pkg::H0;
			chain_q[1] <= md4_pkg::H1;
			chain_q[2] <= md4_pkg::H2;
			chain_q[3] <= md4_pkg::H3;
			step_q     <= '0;
			fin_q      <= 1'b0;
			emit_n_q   <= '0;
			owr_q      <= '0;
			ord_q      <= '0;
			ocnt_q     <= '0;
		end else begin
			case (state_q)
				CS_IDLE: begin
					if (stat.head_valid) begin
						step_q  <= '0;
						fin_q   <= stat.head_final;
						state_q <= CS_RUN;
					end
				end
				CS_RUN: begin
					step_q <= step_q + 6'd1;
					if (last_step)
						state_q <= CS_ADD;
				end
				CS_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					emit_n_q   <= '0;
					state_q    <= fin_q ? CS_EMIT : CS_IDLE;
				end
				CS_EMIT: begin
					if (opush) begin
						emit_n_q <= emit_n_q + 2'd1;
						if (emit_n_q == 2'd3) begin
							chain_q[0] <= md4_pkg::H0;
							chain_q[1] <= md4_pkg::H1;
							chain_q[2] <= md4_pkg::H2;
							chain_q[3] <= md4_pkg::H3;
							state_q    <= CS_IDLE;
						end
					end
				end
				default: state_q <= CS_IDLE;
			endcase

			// result queue pointers
			if (opush)
				owr_q <= owr_q + 2'd1;
			if (opop)
				ord_q <= ord_q + 2'd1;
			if (opush && !opop)
				ocnt_q <= ocnt_q + 3'd1;
			else if (opop && !opush)
				ocnt_q <= ocnt_q - 3'd1;
		end
	end

endmodule

FILE: bench/md4_digest_check.sv
`timescale 1ns / 100ps

module md4_digest_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  md4_pkg::in_item_t   item,
	input  logic                empty,
	input  logic                pop,
	input  md4_pkg::out_item_t  result,
	output int                  fail_count,
	output int                  words_pending,
	output int                  digests_checked,
	output int                  spill_count
);

	// running hash state of the message in progress
	logic [31:0] hash_state [4];
	logic [31:0] msg_block [16];
	logic [63:0] msg_bits;

	// digest words owed by the block, oldest first
	md4_pkg::out_item_t digest_words_due [$];

	function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// rotate amount per round and step lane
	function automatic int step_shift(input int rnd, input int lane);
		case (rnd)
			0: case (lane)
				0: return 3;
				1: return 7;
				2: return 11;
				default: return 19;
			endcase
			1: case (lane)
				0: return 3;
				1: return 5;
				2: return 9;
				default: return 13;
			endcase
			default: case (lane)
				0: return 3;
				1: return 9;
				2: return 11;
				default: return 15;
			endcase
		endcase
	endfunction

	function automatic void restart_hash();
		hash_state[0] = md4_pkg::H0;
		hash_state[1] = md4_pkg::H1;
		hash_state[2] = md4_pkg::H2;
		hash_state[3] = md4_pkg::H3;
		for (int w = 0; w < 16; w++) msg_block[w] = 32'h0;
		msg_bits = 64'h0;
	endfunction

	// 48-step compression of msg_block into hash_state
	function automatic void md4_compress();
		logic [31:0] a, b, c, d, f, t;
		logic [3:0] j;
		int k;
		int rnd;
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		for (int i = 0; i < md4_pkg::STEPS; i++) begin
			j = 4'(i % 16);
			rnd = i / 16;
			case (rnd)
				0: begin
					f = (b & c) | (~b & d);
					k = j;
				end
				1: begin
					f = ((b & c) | (b & d) | (c & d)) + md4_pkg::K2;
					k = j[1:0] * 4 + j[3:2];
				end
				default: begin
					f = (b ^ c ^ d) + md4_pkg::K3;
					k = {j[0], j[1], j[2], j[3]};
				end
			endcase
			t = rol32(a + f + msg_block[k], step_shift(rnd, i % 4));
			a = d;
			d = c;
			c = b;
			b = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
	endfunction

	function automatic void put_byte(input int pos, input logic [7:0] b);
		msg_block[pos / 4][8 * (pos % 4) +: 8] = b;
	endfunction

	// fold one accepted input item into the hash, queue digest on end of message
	function automatic void absorb_item(input md4_pkg::in_item_t it);
		int pos;
		if (it.byte_valid) begin
			pos = int'(msg_bits[8:3]);
			put_byte(pos, it.data_byte);
			msg_bits += 64'd8;
			if (pos == 63) md4_compress();
		end
		if (!it.end_of_message) return;

		// pad marker, zero fill, length in the last two words
		pos = int'(msg_bits[8:3]);
		put_byte(pos, md4_pkg::PAD_MARK);
		for (int p = pos + 1; p < 64; p++) put_byte(p, 8'h00);
		if (pos >= md4_pkg::LEN_POS) begin
			md4_compress();
			for (int w = 0; w < 14; w++) msg_block[w] = 32'h0;
			spill_count++;
		end
		msg_block[14] = msg_bits[31:0];
		msg_block[15] = msg_bits[63:32];
		md4_compress();

		for (int w = 0; w < 4; w++)
			digest_words_due.push_back('{digest_word: hash_state[w],
				word_number: 2'(w), last_word: (w == 3)});
		restart_hash();
	endfunction

	function automatic void check_word(input md4_pkg::out_item_t got);
		md4_pkg::out_item_t want;
		if (digest_words_due.size() == 0) begin
			$error("digest word with none expected: digest_word %h word_number %0d",
				got.digest_word, got.word_number);
			fail_count++;
			return;
		end
		want = digest_words_due.pop_front();
		if (got.digest_word !== want.digest_word) begin
			$error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
			fail_count++;
		end
		if (got.word_number !== want.word_number) begin
			$error("word_number: expected %0d, actual %0d", want.word_number,
				got.word_number);
			fail_count++;
		end
		if (got.last_word !== want.last_word) begin
			$error("last_word: expected %b, actual %b", want.last_word, got.last_word);
			fail_count++;
		end
		if (want.last_word) digests_checked++;
	endfunction

	// watch both channels; an input transfer is folded in before a result transfer is checked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_hash();
			digest_words_due.delete();
			fail_count = 0;
			digests_checked = 0;
			spill_count = 0;
			words_pending = 0;
		end else begin
			if (push && !full) absorb_item(item);
			if (pop && !empty) check_word(result);
			words_pending = digest_words_due.size();
		end
	end

endmodule

FILE: bench/md4_hash_engine_test.sv
`timescale 1ns / 100ps

module md4_hash_engine_test;

	localparam int ITEMS_TARGET = 430;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 150;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic empty;
	logic pop;
	md4_pkg::in_item_t  item;
	md4_pkg::out_item_t result;

	int fail_count;
	int words_pending;
	int digests_checked;
	int spill_count;

	int gap_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int messages_sent = 0;
	int cycle_count = 0;

	md4_hash_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	md4_digest_check u_digest_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.item            (item),
		.empty           (empty),
		.pop             (pop),
		.result          (result),
		.fail_count      (fail_count),
		.words_pending   (words_pending),
		.digests_checked (digests_checked),
		.spill_count     (spill_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// digest side: random stalls on pop
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	// cycle limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped at cycle limit %0d", CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				gap_pct = 56;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct = 0;
				stall_pct = 56;
			end
			default: begin
				gap_pct = 7;
				stall_pct = 7;
			end
		endcase
	endfunction

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(input logic [7:0] b, input logic v, input logic e);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{data_byte: b, byte_valid: v, end_of_message: e};
		@(posedge clk);
		while (full) @(posedge clk);
		if (v || e) items_sent++;
		if (e) messages_sent++;
	endtask

	initial begin
		int len;
		int pick;
		logic tail_byte;

		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored item, empty messages, byte extremes, end with and without byte
		set_idle(IDLE_NONE);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'hFE, 1'b1, 1'b0);
		send_item(8'hC3, 1'b0, 1'b1);

		// random messages: short, near the pad spill point, and over two blocks
		while (items_sent < ITEMS_TARGET) begin
			set_idle(idle_mode_t'((items_sent * 4 / ITEMS_TARGET) % 4));
			pick = $urandom_range(99);
			if (pick < 45)
				len = $urandom_range(10, 0);
			else if (pick < 85)
				len = $urandom_range(66, 52);
			else
				len = $urandom_range(130, 115);
			tail_byte = (len > 0) && ($urandom_range(1) == 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 8) send_item(8'($urandom), 1'b0, 1'b0);
				send_item(8'($urandom), 1'b1, (i == len - 1) && tail_byte);
			end
			if (!tail_byte) send_item(8'($urandom), 1'b0, 1'b1);
		end
		push <= 1'b0;

		// drain outstanding digest words
		@(negedge clk);
		while (words_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d message items over %0d messages, %0d digests compared word by word",
			items_sent, messages_sent, digests_checked);
		$display("%0d messages needed an extra length block; idle modes none/send/recv/both",
			spill_count);
		if (fail_count == 0 && words_pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: md4_hash_engine.f
design/md4_pkg.sv
design/md4_blkq.sv
design/md4_front.sv
design/md4_core.sv
design/md4_hash_engine.sv
bench/md4_digest_check.sv
bench/md4_hash_engine_test.sv
